### rtl/core/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// Holds register indexes, op codes, fixed field widths and the result record.
// No dependencies.
`timescale 1ns / 1ps

package lir_pkg;

  // Fixed field and register widths
  localparam int OP_W        = 2;
  localparam int ADDR_IN_W   = 12;
  localparam int PCM_W       = 16;
  localparam int POS_W       = 32;
  localparam int STEP_W      = 19;
  localparam int CLIP_W      = 13;
  localparam int STRIDE_W    = 4;
  localparam int CFG_DATA_W  = 19;
  localparam int CFG_INDEX_W = 2;

  // Item op codes
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_RATIO     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_FRAMES    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_STRIDE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_ENABLE    = 2'd3;

  // Register reset values
  localparam logic [STEP_W-1:0]   STEP_RATIO_RESET     = 19'd65536;
  localparam logic [CLIP_W-1:0]   CLIP_FRAMES_RESET    = 13'd0;
  localparam logic [STRIDE_W-1:0] CHANNEL_STRIDE_RESET = 4'd1;

  // Output queue sizing
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  // Tick context that travels with the sample reads
  typedef struct packed {
    logic valid;
    logic ended;
  } tick_tag_t;

  // One result item
  typedef struct packed {
    logic signed [PCM_W-1:0] sample;
    logic                    ended;
  } result_t;

endpackage

### rtl/core/lir_ram.sv
// Generic single-port RAM with registered read.
// One read or one write per cycle; read data holds until the next read.
// No dependencies.
`timescale 1ns / 1ps

module lir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read the addressed entry
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### rtl/core/lir_sched.sv
// Item acceptance, play position and sample RAM port sequencing.
// Issues the two frame reads of a tick, the second from the registered phase and next address, and tags the pipeline.
// Depends on lir_pkg.
`timescale 1ns / 1ps

module lir_sched import lir_pkg::*; #(
  parameter int ADDR_W   = 12,
  parameter int FRAC_W   = 16,
  parameter int SAMPLE_W = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            op,
  input  logic [ADDR_IN_W-1:0]       write_address,
  input  logic signed [PCM_W-1:0]    write_value,
  input  logic [STEP_W-1:0]          step_ratio,
  input  logic [CLIP_W-1:0]          clip_frames,
  input  logic [STRIDE_W-1:0]        channel_stride,
  input  logic                       loop_enable,
  input  logic                       room,
  output logic                       tick_accept,
  output logic                       ram_en,
  output logic                       ram_we,
  output logic [ADDR_W-1:0]          ram_addr,
  output logic [SAMPLE_W-1:0]        ram_wdata,
  output tick_tag_t                  tag,
  output logic [FRAC_W-1:0]          frac
);

  localparam int IDX_W  = POS_W - FRAC_W;
  localparam int PROD_W = STRIDE_W + CLIP_W;

  logic [POS_W-1:0]           position;
  logic [POS_W-1:0]           position_next;
  logic                       phase;
  logic [ADDR_W-1:0]          nxt_addr;
  logic                       accept;
  logic [IDX_W-1:0]           idx;
  logic                       in_clip;
  logic [CLIP_W-1:0]          idx_frame;
  logic [CLIP_W:0]            idx_plus;
  logic [CLIP_W-1:0]          nxt_frame;
  logic [PROD_W-1:0]          addr0_full;
  logic [PROD_W-1:0]          addr1_full;
  logic signed [SAMPLE_W-1:0] store_value;

  assign in_ready    = !phase && room;
  assign accept      = in_valid && in_ready;
  assign tick_accept = accept && (op == OP_TICK);

  // Split the position into frame index and fraction
  assign idx       = position[POS_W-1:FRAC_W];
  assign in_clip   = (POS_W'(idx) < POS_W'(clip_frames));
  assign idx_frame = CLIP_W'(idx);
  assign idx_plus  = {1'b0, idx_frame} + {{CLIP_W{1'b0}}, 1'b1};
  assign nxt_frame = (idx_plus >= {1'b0, clip_frames}) ? idx_frame : idx_plus[CLIP_W-1:0];

  // Frame addresses wrap at the memory depth
  assign addr0_full = channel_stride * idx_frame;
  assign addr1_full = channel_stride * nxt_frame;

  assign store_value = SAMPLE_W'(write_value);

  // Drive the RAM port: second read has priority, else the accepted item
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = ADDR_W'(addr0_full);
    ram_wdata = store_value;
    if (phase) begin
      ram_en   = 1'b1;
      ram_addr = nxt_addr;
    end else if (accept && op == OP_WRITE) begin
      ram_en   = 1'b1;
      ram_we   = 1'b1;
      ram_addr = ADDR_W'(write_address);
    end else if (tick_accept) begin
      ram_en = 1'b1;
    end
  end

  // Advance, hold or clear the play position
  always_comb begin
    position_next = position;
    if (accept) begin
      unique case (op)
        OP_RESTART: position_next = '0;
        OP_TICK: begin
          if (in_clip) begin
            position_next = position + POS_W'(step_ratio);
          end else if (loop_enable) begin
            position_next = '0;
          end
        end
        default: position_next = position;
      endcase
    end
  end

  // Control state and tick tag
  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      phase     <= 1'b0;
      tag.valid <= 1'b0;
    end else begin
      position  <= position_next;
      phase     <= tick_accept;
      tag.valid <= tick_accept;
      if (tick_accept) begin
        tag.ended <= !in_clip;
      end
    end
  end

  // Tick context for the blend pipeline
  always_ff @(posedge clk) begin
    if (tick_accept) begin
      frac      <= position[FRAC_W-1:0];
      nxt_addr  <= ADDR_W'(addr1_full);
    end
  end

endmodule

### rtl/core/lir_blend.sv
// Interpolation datapath: captures both frames, multiplies, truncates.
// Computes s0 + (s1 - s0) * f / 2^F with truncation toward zero.
// Depends on lir_pkg.
`timescale 1ns / 1ps

module lir_blend import lir_pkg::*; #(
  parameter int FRAC_W   = 16,
  parameter int SAMPLE_W = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tick_tag_t                  tag,
  input  logic [FRAC_W-1:0]          frac,
  input  logic signed [SAMPLE_W-1:0] rdata,
  output logic                       push,
  output result_t                    result
);

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = SAMPLE_W + FRAC_W + 2;
  localparam int ACC_W  = SAMPLE_W + FRAC_W + 2;

  logic                       v2;
  logic                       e2;
  logic [FRAC_W-1:0]          frac2;
  logic signed [SAMPLE_W-1:0] s0_q;
  logic                       v3;
  logic                       e3;
  logic signed [SAMPLE_W-1:0] s0_3;
  logic signed [PROD_W-1:0]   prod3;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    quot;
  logic                       round_up;
  logic signed [ACC_W-1:0]    value;

  // Stage 2 valid, stage 3 valid, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v2   <= 1'b0;
      v3   <= 1'b0;
      push <= 1'b0;
    end else begin
      v2   <= tag.valid;
      v3   <= v2;
      push <= v3;
    end
  end

  // Capture the first frame
  always_ff @(posedge clk) begin
    if (tag.valid) begin
      s0_q  <= rdata;
      e2    <= tag.ended;
      frac2 <= frac;
    end
  end

  // Multiply the frame difference by the fraction
  assign diff = DIFF_W'(rdata) - DIFF_W'(s0_q);
  assign prod = diff * $signed({1'b0, frac2});

  always_ff @(posedge clk) begin
    if (v2) begin
      prod3 <= prod;
      s0_3  <= s0_q;
      e3    <= e2;
    end
  end

  // Add the base, shift out the fraction, round negative values up
  assign acc      = (ACC_W'(s0_3) <<< FRAC_W) + prod3;
  assign quot     = acc >>> FRAC_W;
  assign round_up = acc[ACC_W-1] && (|acc[FRAC_W-1:0]);
  assign value    = quot + ACC_W'(round_up);

  always_ff @(posedge clk) begin
    if (v3) begin
      result.sample <= e3 ? '0 : value[PCM_W-1:0];
      result.ended  <= e3;
    end
  end

endmodule

### rtl/core/lir_outq.sv
// Output queue for result items and the credit count of ticks in flight.
// A tick is taken only while a queue slot is reserved for its result.
// Depends on lir_pkg.
`timescale 1ns / 1ps

module lir_outq import lir_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    tick_accept,
  input  logic    push,
  input  result_t push_data,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t head,
  output logic    room
);

  result_t               entries [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic [OUTQ_CNT_W-1:0] count;
  logic [OUTQ_CNT_W-1:0] pending;
  logic [OUTQ_CNT_W-1:0] pending_next;
  logic                  pop;

  assign out_valid = (count != '0);
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room      = (pending < OUTQ_CNT_W'(OUTQ_DEPTH));

  // Reserve on tick accept, release on pop
  always_comb begin
    pending_next = pending;
    if (tick_accept && !pop) begin
      pending_next = pending + 1'b1;
    end else if (!tick_accept && pop) begin
      pending_next = pending - 1'b1;
    end
  end

  // Queue pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      pending <= '0;
    end else begin
      pending <= pending_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming result
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/core/linear_interp_resampler.sv
// Linear interpolation resampler: plays back a stored clip at a set rate.
// A tick blocks the input for its second read of the single-port sample RAM;
// write and restart items do not. Results pass the RAM read, blend registers
// and output queue; up to 4 may wait at the output. Reset zeroes the play
// position and loads register defaults; the sample RAM is not cleared and
// needs no clearing pass. MEMORY_DEPTH must be a power of two; not checked.
`timescale 1ns / 1ps

module linear_interp_resampler import lir_pkg::*; #(
  parameter int MEMORY_DEPTH  = 4096,
  parameter int FRACTION_BITS = 16,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         op,
  input  logic [ADDR_IN_W-1:0]    write_address,
  input  logic signed [PCM_W-1:0] write_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PCM_W-1:0] sample_out,
  output logic                    ended,
  input  logic                    cfg_write,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int ADDR_W = $clog2(MEMORY_DEPTH);

  logic [STEP_W-1:0]          step_ratio;
  logic [CLIP_W-1:0]          clip_frames;
  logic [STRIDE_W-1:0]        channel_stride;
  logic                       loop_enable;
  logic                       room;
  logic                       tick_accept;
  logic                       ram_en;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_addr;
  logic [SAMPLE_BITS-1:0]     ram_wdata;
  logic [SAMPLE_BITS-1:0]     ram_rdata;
  tick_tag_t                  tag;
  logic [FRACTION_BITS-1:0]   frac;
  logic                       push;
  result_t                    push_data;
  result_t                    head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio     <= STEP_RATIO_RESET;
      clip_frames    <= CLIP_FRAMES_RESET;
      channel_stride <= CHANNEL_STRIDE_RESET;
      loop_enable    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEP_RATIO:     step_ratio     <= cfg_data[STEP_W-1:0];
        REG_CLIP_FRAMES:    clip_frames    <= cfg_data[CLIP_W-1:0];
        REG_CHANNEL_STRIDE: channel_stride <= cfg_data[STRIDE_W-1:0];
        REG_LOOP_ENABLE:    loop_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lir_sched #(
    .ADDR_W   (ADDR_W),
    .FRAC_W   (FRACTION_BITS),
    .SAMPLE_W (SAMPLE_BITS)
  ) u_sched (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .write_address  (write_address),
    .write_value    (write_value),
    .step_ratio     (step_ratio),
    .clip_frames    (clip_frames),
    .channel_stride (channel_stride),
    .loop_enable    (loop_enable),
    .room           (room),
    .tick_accept    (tick_accept),
    .ram_en         (ram_en),
    .ram_we         (ram_we),
    .ram_addr       (ram_addr),
    .ram_wdata      (ram_wdata),
    .tag            (tag),
    .frac           (frac)
  );

  lir_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MEMORY_DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  lir_blend #(
    .FRAC_W   (FRACTION_BITS),
    .SAMPLE_W (SAMPLE_BITS)
  ) u_blend (
    .clk    (clk),
    .rst    (rst),
    .tag    (tag),
    .frac   (frac),
    .rdata  ($signed(ram_rdata)),
    .push   (push),
    .result (push_data)
  );

  lir_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .tick_accept (tick_accept),
    .push        (push),
    .push_data   (push_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .head        (head),
    .room        (room)
  );

  assign sample_out = head.sample;
  assign ended      = head.ended;

endmodule

### tb/linear_interp_resampler_tb.sv
// Self-checking testbench for the linear interpolation resampler.
// Drives random and directed items through valid/ready, predicts every tick.
// Depends on lir_pkg and linear_interp_resampler.
`timescale 1ns / 1ps

import lir_pkg::*;

// Tracks clip memory, play position and registers; queues expected samples
class resampler_scoreboard;
  localparam int MEM_DEPTH = 4096;
  localparam int FRAC_BITS = 16;
  localparam longint UNITY = 64'd1 << FRAC_BITS;

  logic signed [PCM_W-1:0] pcm_mem [MEM_DEPTH];
  bit                      written [MEM_DEPTH];
  logic [POS_W-1:0]        position;
  logic [STEP_W-1:0]       step;
  logic [CLIP_W-1:0]       clip;
  logic [STRIDE_W-1:0]     stride;
  bit                      looping;
  result_t                 expected_q[$];
  int                      errors;

  function new();
    position = '0;
    step     = STEP_RATIO_RESET;
    clip     = CLIP_FRAMES_RESET;
    stride   = CHANNEL_STRIDE_RESET;
    looping  = 1'b0;
    errors   = 0;
    foreach (written[i]) written[i] = 1'b0;
  endfunction

  function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_STEP_RATIO:     step    = data[STEP_W-1:0];
      REG_CLIP_FRAMES:    clip    = data[CLIP_W-1:0];
      REG_CHANNEL_STRIDE: stride  = data[STRIDE_W-1:0];
      REG_LOOP_ENABLE:    looping = data[0];
      default: ;
    endcase
  endfunction

  function int unsigned frame_addr(int unsigned frame);
    return (frame * stride) % MEM_DEPTH;
  endfunction

  function int unsigned neighbor_of(int unsigned frame);
    return (frame + 1 >= clip) ? frame : frame + 1;
  endfunction

  // Return a memory address the next tick would read unwritten, else -1
  function int missing_frame();
    int unsigned frame;
    frame = position >> FRAC_BITS;
    if (frame >= clip) return -1;
    if (!written[frame_addr(frame)]) return frame_addr(frame);
    if (!written[frame_addr(neighbor_of(frame))]) return frame_addr(neighbor_of(frame));
    return -1;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Apply one accepted item and queue its sample, if any
  function void note_item(logic [OP_W-1:0] code, logic [ADDR_IN_W-1:0] addr,
                          logic signed [PCM_W-1:0] value);
    int unsigned frame;
    longint      frac;
    longint      blend;
    result_t     want;
    case (code)
      OP_WRITE: begin
        pcm_mem[addr] = value;
        written[addr] = 1'b1;
      end
      OP_RESTART: position = '0;
      OP_TICK: begin
        frame = position >> FRAC_BITS;
        if (frame < clip) begin
          frac  = longint'(position[FRAC_BITS-1:0]);
          blend = (longint'(pcm_mem[frame_addr(frame)]) * (UNITY - frac) +
                   longint'(pcm_mem[frame_addr(neighbor_of(frame))]) * frac) / UNITY;
          want.sample = blend[PCM_W-1:0];
          want.ended  = 1'b0;
          position    = position + POS_W'(step);
        end else begin
          want.sample = '0;
          want.ended  = 1'b1;
          if (looping) position = '0;
        end
        expected_q.push_back(want);
      end
      default: ;
    endcase
  endfunction

  // Compare one accepted sample with the oldest expectation
  function void check_result(logic signed [PCM_W-1:0] sample, logic done_flag);
    result_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result: sample_out %0d ended %0b", sample, done_flag);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (sample !== want.sample) begin
      $error("sample_out: expected %0d, got %0d", want.sample, sample);
      errors++;
    end
    if (done_flag !== want.ended) begin
      $error("ended: expected %0b, got %0b", want.ended, done_flag);
      errors++;
    end
  endfunction
endclass

module linear_interp_resampler_tb;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS  = 103;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         op = '0;
  logic [ADDR_IN_W-1:0]    write_address = '0;
  logic signed [PCM_W-1:0] write_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [PCM_W-1:0] sample_out;
  logic                    ended;
  logic                    cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  resampler_scoreboard sb;
  bit calm = 1'b0;
  int ready_left = 0;
  int stall_cycles = 0;

  linear_interp_resampler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .write_address(write_address), .write_value(write_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample_out(sample_out), .ended(ended),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Toggle out_ready in random bursts; hold it high in the calm stretch
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_left <= 0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_ready  <= 1'b0;
        ready_left <= $urandom_range(1, 15);
      end else begin
        out_ready  <= 1'b1;
        ready_left <= $urandom_range(1, 20);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // Check every accepted sample
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(sample_out, ended);
  end

  // Abort when no item moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one item, wait for the handshake, then record it
  task automatic send_item(logic [OP_W-1:0] code, logic [ADDR_IN_W-1:0] addr,
                           logic signed [PCM_W-1:0] value);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= code;
    write_address <= addr;
    write_value   <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_item(code, addr, value);
  endtask

  // Drop valid, drain all samples, let in-flight writes retire
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    sb.set_reg(idx, CFG_DATA_W'(value));
  endtask

  task automatic program_regs(int unsigned step, int unsigned clip, int unsigned stride,
                              int unsigned looping);
    write_reg(REG_STEP_RATIO, step);
    write_reg(REG_CLIP_FRAMES, clip);
    write_reg(REG_CHANNEL_STRIDE, stride);
    write_reg(REG_LOOP_ENABLE, looping);
    cfg_write <= 1'b0;
  endtask

  // Random playback: mostly ticks, with fills so no unwritten entry is read
  task automatic play_phase(int unsigned step, int unsigned clip, int unsigned stride,
                            int unsigned looping, int unsigned restart_pct);
    int n;
    int miss;
    int pick;
    settle();
    program_regs(step, clip, stride, looping);
    n = 0;
    while (n < PHASE_ITEMS) begin
      miss = sb.missing_frame();
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        if (miss >= 0)
          send_item(OP_WRITE, ADDR_IN_W'(miss), PCM_W'($urandom));
        else
          send_item(OP_TICK, ADDR_IN_W'($urandom), PCM_W'($urandom));
      end else if (pick < 62 + restart_pct) begin
        send_item(OP_RESTART, ADDR_IN_W'($urandom), PCM_W'($urandom));
      end else if (pick < 65 + restart_pct) begin
        send_item(OP_UNUSED, ADDR_IN_W'($urandom), PCM_W'($urandom));
        n--;
      end else begin
        send_item(OP_WRITE, ADDR_IN_W'($urandom), PCM_W'($urandom));
      end
      n++;
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty clip after reset reports ended; unused op is dropped
    send_item(OP_TICK, '0, '0);
    send_item(OP_UNUSED, '1, '1);
    settle();

    // Half-frame steps over a three-frame clip with extreme samples
    program_regs(32'h8000, 3, 1, 0);
    send_item(OP_WRITE, 12'd0, 16'sh7FFF);
    send_item(OP_WRITE, 12'd1, -16'sh8000);
    send_item(OP_WRITE, 12'd2, -16'sd1);
    send_item(OP_WRITE, 12'hFFF, 16'sh5555);
    repeat (8) send_item(OP_TICK, '0, '0);
    send_item(OP_RESTART, '0, '0);
    send_item(OP_TICK, '0, '0);

    // Sweep register settings, extremes among them
    play_phase(32'h10000, 16, 1, 0, 8);
    play_phase(1, 2, 1, 1, 8);
    play_phase(32'h7FFFF, 4096, 15, 1, 1);
    play_phase(32'h2A3B, 40, 0, 0, 8);
    play_phase(32'h18000, 8191, 8, 1, 2);
    play_phase(0, 5, 3, 1, 8);
    play_phase(32'hC000, 1, 1, 1, 8);
    play_phase(40000, 0, 2, 1, 8);
    play_phase($urandom_range(1, 1 << 18), $urandom_range(1, 64),
               $urandom_range(0, 15), $urandom_range(0, 1), 6);
    calm = 1'b1;
    play_phase(32'h13333, 100, 4, 1, 5);

    settle();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
